### rtl/core/pgmd_pkg.sv
`timescale 1ns / 1ps
package pgmd_pkg;

  localparam int GRID_SIDE = 32;
  localparam int FRACTION_BITS = 16;
  localparam int AXIS_BITS = $clog2(GRID_SIDE);
  localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int CELL_BITS = 3 * AXIS_BITS;
  localparam int POS_BITS = 21;
  localparam int ACC_BITS = 48;
  localparam int W_BITS = FRACTION_BITS + 1;

  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

  localparam logic CFG_DEPOSIT_MODE = 1'b0;
  localparam logic CFG_VOLUME_SCALE = 1'b1;

  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  typedef struct packed {
    logic [1:0] command;
    logic nearest;
    logic [AXIS_BITS-1:0] bx;
    logic [AXIS_BITS-1:0] by;
    logic [AXIS_BITS-1:0] bz;
    logic [FRACTION_BITS-1:0] fx;
    logic [FRACTION_BITS-1:0] fy;
    logic [FRACTION_BITS-1:0] fz;
    logic [31:0] luminosity;
    logic [31:0] volume_scale;
    logic [14:0] cell_index;
    logic last_in_batch;
  } job_t;

endpackage

### rtl/core/pgmd_front.sv
`timescale 1ns / 1ps
module pgmd_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [20:0] in_pos_x,
  input  logic [20:0] in_pos_y,
  input  logic [20:0] in_pos_z,
  input  logic [31:0] in_luminosity,
  input  logic [14:0] in_cell_index,
  input  logic in_last_in_batch,
  input  logic deposit_mode,
  input  logic [31:0] volume_scale,
  output logic job_valid,
  input  logic job_take,
  output pgmd_pkg::job_t job
);
  import pgmd_pkg::*;

  job_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  job_t j;
  logic push;

  always_comb begin
    j.command = in_command;
    j.nearest = deposit_mode;
    j.bx = in_pos_x[FRACTION_BITS +: AXIS_BITS];
    j.by = in_pos_y[FRACTION_BITS +: AXIS_BITS];
    j.bz = in_pos_z[FRACTION_BITS +: AXIS_BITS];
    j.fx = in_pos_x[FRACTION_BITS-1:0];
    j.fy = in_pos_y[FRACTION_BITS-1:0];
    j.fz = in_pos_z[FRACTION_BITS-1:0];
    j.luminosity = in_luminosity;
    j.volume_scale = volume_scale;
    j.cell_index = in_cell_index;
    j.last_in_batch = in_last_in_batch;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, job_take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (job_take) rp_r <= !rp_r;
    end
    if (push) q_r[wp_r] <= j;
  end
endmodule

### rtl/core/pgmd_back.sv
`timescale 1ns / 1ps
module pgmd_back (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_take,
  input  pgmd_pkg::job_t job,
  output logic out_valid,
  input  logic out_stall,
  output logic [47:0] out_cell_value,
  output logic out_batch_done,
  output logic out_saturated
);
  import pgmd_pkg::*;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_AMT = 4'd2;
  localparam logic [3:0] S_WXY = 4'd3;
  localparam logic [3:0] S_W = 4'd4;
  localparam logic [3:0] S_CON = 4'd5;
  localparam logic [3:0] S_RD = 4'd6;
  localparam logic [3:0] S_WR = 4'd7;
  localparam logic [3:0] S_CMD_RD = 4'd8;
  localparam logic [3:0] S_CMD_WR = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  logic [ACC_BITS-1:0] mem [CELLS];
  logic [ACC_BITS-1:0] rdata_r;
  logic [3:0] st_r, st_nxt;
  logic [CELL_BITS-1:0] clr_r;
  job_t jb_r;
  logic [2:0] k_r;
  logic [ACC_BITS-1:0] amt_r, con_r;
  logic [W_BITS-1:0] wxy_r, w_r;
  logic sat_r;
  logic ov_r;
  logic [47:0] ov_val_r;
  logic ov_bd_r;

  logic [W_BITS-1:0] wx, wy, wz;
  logic [AXIS_BITS-1:0] cx, cy, cz;
  logic [CELL_BITS-1:0] addr;
  logic [2*W_BITS-1:0] pxy, pw;
  logic [ACC_BITS:0] sum;
  logic [ACC_BITS-1:0] sum_c;

  always_comb begin
    wx = k_r[2] ? {1'b0, jb_r.fx} : W_BITS'(1 << FRACTION_BITS) - {1'b0, jb_r.fx};
    wy = k_r[1] ? {1'b0, jb_r.fy} : W_BITS'(1 << FRACTION_BITS) - {1'b0, jb_r.fy};
    wz = k_r[0] ? {1'b0, jb_r.fz} : W_BITS'(1 << FRACTION_BITS) - {1'b0, jb_r.fz};
    if (jb_r.nearest) begin
      cx = jb_r.bx + AXIS_BITS'(jb_r.fx > FRACTION_BITS'(1 << (FRACTION_BITS-1)));
      cy = jb_r.by + AXIS_BITS'(jb_r.fy > FRACTION_BITS'(1 << (FRACTION_BITS-1)));
      cz = jb_r.bz + AXIS_BITS'(jb_r.fz > FRACTION_BITS'(1 << (FRACTION_BITS-1)));
    end else begin
      cx = jb_r.bx + AXIS_BITS'(k_r[2]);
      cy = jb_r.by + AXIS_BITS'(k_r[1]);
      cz = jb_r.bz + AXIS_BITS'(k_r[0]);
    end
    addr = (st_r == S_CMD_RD || st_r == S_CMD_WR) ?
           jb_r.cell_index[CELL_BITS-1:0] : {cx, cy, cz};
    pxy = wx * wy;
    pw = wxy_r * wz;
    sum = {1'b0, rdata_r} + {1'b0, con_r};
    sum_c = (sum >= {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_BITS-1:0];
  end

  logic idx_ok;
  assign idx_ok = ({17'd0, jb_r.cell_index} < 32'(CELLS));

  assign job_take = (st_r == S_IDLE) && job_valid && !ov_r;
  assign out_valid = ov_r;
  assign out_cell_value = ov_val_r;
  assign out_batch_done = ov_bd_r;
  assign out_saturated = sat_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLR: if (clr_r == CELL_BITS'(CELLS - 1)) st_nxt = S_IDLE;
      S_IDLE: begin
        if (job_take) begin
          unique case (job.command) inside
            CMD_DEPOSIT: st_nxt = S_AMT;
            CMD_READ, CMD_READ_CLEAR: st_nxt = S_CMD_RD;
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_AMT: st_nxt = S_WXY;
      S_WXY: st_nxt = S_W;
      S_W: st_nxt = S_CON;
      S_CON: st_nxt = S_RD;
      S_RD: st_nxt = S_WR;
      S_WR: begin
        if (jb_r.nearest || k_r == 3'd7) st_nxt = S_OUT;
        else st_nxt = S_WXY;
      end
      S_CMD_RD: st_nxt = S_CMD_WR;
      S_CMD_WR: st_nxt = S_IDLE;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      sat_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + CELL_BITS'(1);
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (st_r == S_WR && sum >= {1'b0, ACC_MAX}) sat_r <= 1'b1;
      if (st_r == S_OUT && jb_r.last_in_batch) ov_r <= 1'b1;
      if (st_r == S_CMD_WR) ov_r <= 1'b1;
    end
    if (job_take) begin
      jb_r <= job;
      k_r <= 3'd0;
    end
    if (st_r == S_AMT) amt_r <= ACC_BITS'((64'(jb_r.luminosity) * 64'(jb_r.volume_scale)) >> 16);
    if (st_r == S_WXY) wxy_r <= W_BITS'(pxy >> FRACTION_BITS);
    if (st_r == S_W) w_r <= W_BITS'(pw >> FRACTION_BITS);
    if (st_r == S_CON) begin
      if (jb_r.nearest) con_r <= amt_r;
      else con_r <= ACC_BITS'((({24'd0, amt_r[47:24]} * 48'(w_r)) << (24 - FRACTION_BITS))
                  + (({24'd0, amt_r[23:0]} * 48'(w_r)) >> FRACTION_BITS));
    end
    if (st_r == S_WR) k_r <= k_r + 3'd1;
    if (st_r == S_CLR) mem[clr_r] <= '0;
    if (st_r == S_RD || st_r == S_CMD_RD) rdata_r <= mem[addr];
    if (st_r == S_WR) mem[addr] <= sum_c;
    if (st_r == S_CMD_WR && idx_ok && jb_r.command == CMD_READ_CLEAR) mem[addr] <= '0;
    if (st_r == S_CMD_WR) begin
      ov_val_r <= idx_ok ? rdata_r : '0;
      ov_bd_r <= 1'b0;
    end
    if (st_r == S_OUT) begin
      ov_val_r <= '0;
      ov_bd_r <= 1'b1;
    end
  end
endmodule

### rtl/core/particle_grid_mass_deposit_unit.sv
`timescale 1ns / 1ps
// Mass-deposit grid: particles are added into a periodic 32x32x32 grid of
// 48-bit saturating accumulators. The in_ channel takes commands: deposit,
// read cell, or read then clear cell. The out_ channel returns one transfer
// per read command and per deposit that ends a batch; other deposits give none.
// A front end queues up to two commands, so a transfer is accepted while a
// result still waits. The back end runs a cloud-in-cell deposit as S_AMT and
// eight weight, read and write passes through S_WXY, S_W, S_CON, S_RD and S_WR
// on the single grid memory port, a nearest-point deposit as S_AMT and one such
// pass, and a read as S_CMD_RD then S_CMD_WR; every deposit then ends in S_OUT.
// After reset the grid is swept to zero, one cell a cycle, over all 32768 cells;
// the queue takes two input transfers during the sweep and then in_stall holds,
// while configuration writes are taken.
// When out_stall is high the result holds and the back end waits; the queue
// then fills and in_stall rises. The saturated flag is sticky until reset.
module particle_grid_mass_deposit_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [20:0] in_pos_x,
  input  logic [20:0] in_pos_y,
  input  logic [20:0] in_pos_z,
  input  logic [31:0] in_luminosity,
  input  logic [14:0] in_cell_index,
  input  logic in_last_in_batch,
  output logic out_valid,
  input  logic out_stall,
  output logic [47:0] out_cell_value,
  output logic out_batch_done,
  output logic out_saturated
);
  import pgmd_pkg::*;

  logic mode_r;
  logic [31:0] vscale_r;
  logic job_valid, job_take;
  job_t job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      vscale_r <= 32'd65536;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEPOSIT_MODE) mode_r <= cfg_data[0];
      else vscale_r <= cfg_data;
    end
  end

  pgmd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z), .in_luminosity(in_luminosity),
    .in_cell_index(in_cell_index), .in_last_in_batch(in_last_in_batch),
    .deposit_mode(mode_r), .volume_scale(vscale_r),
    .job_valid(job_valid), .job_take(job_take), .job(job)
  );

  pgmd_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_take(job_take),
    .job(job), .out_valid(out_valid), .out_stall(out_stall),
    .out_cell_value(out_cell_value), .out_batch_done(out_batch_done),
    .out_saturated(out_saturated)
  );
endmodule
